@@ sv/bgse_pkg.sv @@
// Shared types, constants and the symbol alphabet of the grouped base32 encoder.
package bgse_pkg;

   localparam int unsigned BYTE_W       = 8;
   localparam int unsigned SYM_W        = 5;
   localparam int unsigned BUF_W        = 12;
   localparam int unsigned CNT_W        = 4;
   localparam int unsigned GROUP_W      = 5;
   localparam int unsigned CSR_INDEX_W  = 2;

   localparam int unsigned SYM_QUEUE_DEPTH = 2;
   localparam int unsigned RSP_QUEUE_DEPTH = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_GROUP_SIZE     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SEPARATOR_CHAR = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SYMBOL31_CHAR  = 2'd2;

   localparam logic [GROUP_W-1:0] GROUP_SIZE_RESET     = 5'd5;
   localparam logic [BYTE_W-1:0]  SEPARATOR_CHAR_RESET = 8'd45;
   localparam logic [BYTE_W-1:0]  SYMBOL31_CHAR_RESET  = 8'd0;

   localparam logic [CNT_W-1:0]   SYM_BITS     = 4'd5;
   localparam logic [CNT_W-1:0]   BYTE_BITS    = 4'd8;
   localparam logic [SYM_W-1:0]   SYM_NO_LETTER = 5'd31;
   localparam logic [GROUP_W-1:0] GROUP_POS_MAX = 5'd31;

   typedef struct packed {
      logic [GROUP_W-1:0] group_size;
      logic [BYTE_W-1:0]  separator_char;
      logic [BYTE_W-1:0]  symbol31_char;
   } cfg_type;

   typedef struct packed {
      logic [SYM_W-1:0] sym;
      logic             last;
   } sym_entry_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_char;
      logic              is_separator;
      logic              last_char;
   } rsp_entry_type;

   function automatic logic [BYTE_W-1:0] letter_of(input logic [SYM_W-1:0] sym);
      logic [BYTE_W-1:0] ch;
      unique case (sym)
         5'd0:  ch = "2";
         5'd1:  ch = "3";
         5'd2:  ch = "4";
         5'd3:  ch = "5";
         5'd4:  ch = "6";
         5'd5:  ch = "7";
         5'd6:  ch = "8";
         5'd7:  ch = "9";
         5'd8:  ch = "A";
         5'd9:  ch = "B";
         5'd10: ch = "C";
         5'd11: ch = "D";
         5'd12: ch = "E";
         5'd13: ch = "F";
         5'd14: ch = "G";
         5'd15: ch = "H";
         5'd16: ch = "J";
         5'd17: ch = "K";
         5'd18: ch = "L";
         5'd19: ch = "M";
         5'd20: ch = "N";
         5'd21: ch = "P";
         5'd22: ch = "Q";
         5'd23: ch = "R";
         5'd24: ch = "T";
         5'd25: ch = "U";
         5'd26: ch = "V";
         5'd27: ch = "W";
         5'd28: ch = "X";
         5'd29: ch = "Y";
         5'd30: ch = "Z";
         default: ch = '0;
      endcase
      return ch;
   endfunction

endpackage

@@ sv/bgse_fifo.sv @@
// Small register-based queue used after each encoder stage.
module bgse_fifo #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ sv/bgse_front.sv @@
// Front stage: takes message bytes and slices the bit buffer into 5-bit symbols.
module bgse_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_push,
   input  logic [bgse_pkg::BYTE_W-1:0]    req_data_byte,
   input  logic                           req_end_of_message,
   output logic                           req_full,
   output logic                           sym_push,
   output bgse_pkg::sym_entry_type        sym_data,
   input  logic                           sym_full
);
   import bgse_pkg::*;

   logic [BUF_W-1:0] buf_ff, buf_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             eom_ff, eom_in;

   logic             accept;
   logic [BUF_W-1:0] w_buf;
   logic [CNT_W-1:0] w_cnt;
   logic             w_eom;
   logic             has_full, has_pad;
   logic [CNT_W-1:0] rem_cnt;
   logic [BUF_W-1:0] shifted;
   logic             last;

   assign req_full = (cnt_ff >= SYM_BITS) || eom_ff;
   assign accept   = req_push && !req_full;

   always_comb begin
      if (accept) begin
         w_buf = {buf_ff[BUF_W-BYTE_W-1:0], req_data_byte};
         w_cnt = cnt_ff + BYTE_BITS;
         w_eom = req_end_of_message;
      end else begin
         w_buf = buf_ff;
         w_cnt = cnt_ff;
         w_eom = eom_ff;
      end
      has_full = (w_cnt >= SYM_BITS);
      has_pad  = !has_full && w_eom && (w_cnt != '0);
      if (has_full) begin
         rem_cnt = w_cnt - SYM_BITS;
         shifted = w_buf >> rem_cnt;
         last    = w_eom && (rem_cnt == '0);
      end else begin
         rem_cnt = '0;
         shifted = w_buf << (SYM_BITS - w_cnt);
         last    = 1'b1;
      end
      sym_data.sym  = shifted[SYM_W-1:0];
      sym_data.last = last;
      sym_push      = (has_full || has_pad) && !sym_full;

      buf_in = w_buf;
      cnt_in = w_cnt;
      eom_in = w_eom;
      if (sym_push) begin
         if (last) begin
            buf_in = '0;
            cnt_in = '0;
            eom_in = 1'b0;
         end else begin
            cnt_in = rem_cnt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_ff <= '0;
         cnt_ff <= '0;
         eom_ff <= 1'b0;
      end else begin
         buf_ff <= buf_in;
         cnt_ff <= cnt_in;
         eom_ff <= eom_in;
      end
   end

endmodule

@@ sv/bgse_back.sv @@
// Back stage: inserts group separators and maps symbols to output characters.
module bgse_back (
   input  logic                      clock,
   input  logic                      reset,
   input  bgse_pkg::cfg_type         cfg,
   input  logic                      sym_empty,
   input  bgse_pkg::sym_entry_type   sym_data,
   output logic                      sym_pop,
   output logic                      rsp_push,
   output bgse_pkg::rsp_entry_type   rsp_data,
   input  logic                      rsp_full
);
   import bgse_pkg::*;

   logic [GROUP_W-1:0] gpos_ff, gpos_in;
   logic               any_ff, any_in;
   logic               sep_needed;

   assign sep_needed = (cfg.group_size != '0) && any_ff && (gpos_ff >= cfg.group_size);
   assign rsp_push   = !sym_empty && !rsp_full;
   assign sym_pop    = rsp_push && !sep_needed;

   always_comb begin
      gpos_in = gpos_ff;
      any_in  = any_ff;
      if (sep_needed) begin
         rsp_data.out_char     = cfg.separator_char;
         rsp_data.is_separator = 1'b1;
         rsp_data.last_char    = 1'b0;
      end else begin
         rsp_data.out_char     = (sym_data.sym == SYM_NO_LETTER) ? cfg.symbol31_char
                                                                : letter_of(sym_data.sym);
         rsp_data.is_separator = 1'b0;
         rsp_data.last_char    = sym_data.last;
      end
      if (rsp_push) begin
         if (sep_needed) begin
            gpos_in = '0;
         end else if (sym_data.last) begin
            gpos_in = '0;
            any_in  = 1'b0;
         end else begin
            gpos_in = (gpos_ff == GROUP_POS_MAX) ? gpos_ff : gpos_ff + 1'b1;
            any_in  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gpos_ff <= '0;
         any_ff  <= 1'b0;
      end else begin
         gpos_ff <= gpos_in;
         any_ff  <= any_in;
      end
   end

endmodule

@@ sv/base32_grouped_serial_encoder_core.sv @@
// Base32 encoder with grouping separators: top level with config registers.
//
// Input queue: drive req_data_byte and req_end_of_message with req_push;
// a transfer happens at a clock edge with req_push high and req_full low.
// Result queue: while rsp_empty is low the oldest character is on
// rsp_out_char, rsp_is_separator and rsp_last_char; it transfers at an edge
// with rsp_pop high. Registers are written through csr_we/csr_index/csr_wdata
// (0 group size, 1 separator byte, 2 byte for symbol 31); the user must write
// them only while idle, which the block does not enforce. The front stage
// emits one symbol a cycle into a symbol queue while it is not full, starting
// in the cycle of the byte transfer (1 or 2 symbols, plus a padding symbol on
// the final byte), and takes no byte while a symbol or a final byte is pending.
// The back stage writes one character or separator a cycle into the result
// queue while a symbol waits and that queue is not full.
// When the receiver stalls, both queues fill and req_full rises; nothing is
// dropped. Synchronous reset empties both queues, clears the bit buffer and
// group state, and restores group size 5, separator 45, symbol-31 byte 0.
module base32_grouped_serial_encoder_core #(
   parameter int unsigned SymQueueDepth = bgse_pkg::SYM_QUEUE_DEPTH,
   parameter int unsigned RspQueueDepth = bgse_pkg::RSP_QUEUE_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   input  logic [bgse_pkg::BYTE_W-1:0]       req_data_byte,
   input  logic                              req_end_of_message,
   output logic                              req_full,
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output logic [bgse_pkg::BYTE_W-1:0]       rsp_out_char,
   output logic                              rsp_is_separator,
   output logic                              rsp_last_char,
   input  logic                              csr_we,
   input  logic [bgse_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [bgse_pkg::BYTE_W-1:0]       csr_wdata
);
   import bgse_pkg::*;

   cfg_type       cfg_ff, cfg_in;
   sym_entry_type sym_wr, sym_rd;
   rsp_entry_type rsp_wr, rsp_rd;
   logic          sym_push, sym_full, sym_pop, sym_empty;
   logic          rsp_push, rsp_full;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_GROUP_SIZE:     cfg_in.group_size     = csr_wdata[GROUP_W-1:0];
            CSR_SEPARATOR_CHAR: cfg_in.separator_char = csr_wdata;
            CSR_SYMBOL31_CHAR:  cfg_in.symbol31_char  = csr_wdata;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.group_size     <= GROUP_SIZE_RESET;
         cfg_ff.separator_char <= SEPARATOR_CHAR_RESET;
         cfg_ff.symbol31_char  <= SYMBOL31_CHAR_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   bgse_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_data_byte      (req_data_byte),
      .req_end_of_message (req_end_of_message),
      .req_full           (req_full),
      .sym_push           (sym_push),
      .sym_data           (sym_wr),
      .sym_full           (sym_full)
   );

   bgse_fifo #(
      .WIDTH ($bits(sym_entry_type)),
      .DEPTH (SymQueueDepth)
   ) u_sym_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (sym_push),
      .push_data (sym_wr),
      .full      (sym_full),
      .pop       (sym_pop),
      .pop_data  (sym_rd),
      .empty     (sym_empty)
   );

   bgse_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .sym_empty (sym_empty),
      .sym_data  (sym_rd),
      .sym_pop   (sym_pop),
      .rsp_push  (rsp_push),
      .rsp_data  (rsp_wr),
      .rsp_full  (rsp_full)
   );

   bgse_fifo #(
      .WIDTH ($bits(rsp_entry_type)),
      .DEPTH (RspQueueDepth)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_wr),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_rd),
      .empty     (rsp_empty)
   );

   assign rsp_out_char     = rsp_rd.out_char;
   assign rsp_is_separator = rsp_rd.is_separator;
   assign rsp_last_char    = rsp_rd.last_char;

`ifndef SYNTHESIS
   a_sep_not_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_is_separator) |-> !rsp_last_char)
      else $error("separator marked as last character");

   a_no_double_sep: assert property (@(posedge clock) disable iff (reset)
      (rsp_push && rsp_wr.is_separator) |=> !(rsp_push && rsp_wr.is_separator))
      else $error("two separators in a row");

   a_sep_holds_symbol: assert property (@(posedge clock) disable iff (reset)
      (rsp_push && rsp_wr.is_separator) |-> !sym_pop)
      else $error("symbol consumed by a separator transfer");
`endif

endmodule

@@ tb/bgse_char_check.sv @@
// Channel monitor for the grouped base32 encoder: predicts every character and compares.
module bgse_char_check (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_push,
   input  logic                             req_full,
   input  logic [bgse_pkg::BYTE_W-1:0]      req_data_byte,
   input  logic                             req_end_of_message,
   input  logic                             rsp_empty,
   input  logic                             rsp_pop,
   input  logic [bgse_pkg::BYTE_W-1:0]      rsp_out_char,
   input  logic                             rsp_is_separator,
   input  logic                             rsp_last_char,
   input  logic                             csr_we,
   input  logic [bgse_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [bgse_pkg::BYTE_W-1:0]      csr_wdata,
   output int                               fail_count,
   output int                               pending_count,
   output int                               chars_checked,
   output int                               separators_checked,
   output int                               messages_checked
);

   localparam logic [8*31-1:0] ALPHABET = "23456789ABCDEFGHJKLMNPQRTUVWXYZ";

   bgse_pkg::cfg_type                  cfg;
   logic [bgse_pkg::BUF_W-1:0]         enc_buf;
   logic [bgse_pkg::CNT_W-1:0]         enc_bits;
   logic [bgse_pkg::GROUP_W-1:0]       grp_pos;
   logic                               char_sent;
   bgse_pkg::rsp_entry_type            expected_chars[$];
   bgse_pkg::rsp_entry_type            want;

   task automatic queue_char(input logic [bgse_pkg::SYM_W-1:0] sym, input logic last);
      bgse_pkg::rsp_entry_type e;
      int s;
      s = sym;
      if (cfg.group_size != 0 && char_sent && grp_pos >= cfg.group_size) begin
         e.out_char = cfg.separator_char;
         e.is_separator = 1'b1;
         e.last_char = 1'b0;
         expected_chars.push_back(e);
         grp_pos = '0;
      end
      if (sym == bgse_pkg::SYM_NO_LETTER) begin
         e.out_char = cfg.symbol31_char;
      end else begin
         e.out_char = ALPHABET[8*(30-s) +: 8];
      end
      e.is_separator = 1'b0;
      e.last_char = last;
      expected_chars.push_back(e);
      if (grp_pos < bgse_pkg::GROUP_POS_MAX) grp_pos++;
      char_sent = 1'b1;
   endtask

   // MSB-first 5-bit slicing of the byte stream; pad and clear on the final byte
   task automatic encode_byte(input logic [7:0] data, input logic eom);
      int nbits;
      logic [bgse_pkg::SYM_W-1:0] sym;
      logic [bgse_pkg::BUF_W-1:0] shifted;
      nbits = (enc_bits > 4) ? 4 : enc_bits;
      enc_buf = {enc_buf[3:0], data};
      nbits += 8;
      while (nbits >= 5) begin
         nbits -= 5;
         shifted = enc_buf >> nbits;
         sym = shifted[bgse_pkg::SYM_W-1:0];
         queue_char(sym, eom && nbits == 0);
      end
      if (eom) begin
         if (nbits > 0) begin
            shifted = enc_buf << (5 - nbits);
            sym = shifted[bgse_pkg::SYM_W-1:0];
            queue_char(sym, 1'b1);
         end
         enc_buf = '0;
         nbits = 0;
         grp_pos = '0;
         char_sent = 1'b0;
      end
      enc_bits = nbits[bgse_pkg::CNT_W-1:0];
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg.group_size = bgse_pkg::GROUP_SIZE_RESET;
         cfg.separator_char = bgse_pkg::SEPARATOR_CHAR_RESET;
         cfg.symbol31_char = bgse_pkg::SYMBOL31_CHAR_RESET;
         enc_buf = '0;
         enc_bits = '0;
         grp_pos = '0;
         char_sent = 1'b0;
         expected_chars.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               bgse_pkg::CSR_GROUP_SIZE:     cfg.group_size = csr_wdata[bgse_pkg::GROUP_W-1:0];
               bgse_pkg::CSR_SEPARATOR_CHAR: cfg.separator_char = csr_wdata;
               bgse_pkg::CSR_SYMBOL31_CHAR:  cfg.symbol31_char = csr_wdata;
               default: ;
            endcase
         end
         if (req_push && !req_full) encode_byte(req_data_byte, req_end_of_message);
         if (rsp_pop && !rsp_empty) begin
            if (expected_chars.size() == 0) begin
               if (fail_count < 10)
                  $display("%0t: unexpected char %h sep %b last %b", $time,
                           rsp_out_char, rsp_is_separator, rsp_last_char);
               fail_count++;
            end else begin
               want = expected_chars.pop_front();
               if (rsp_out_char !== want.out_char || rsp_is_separator !== want.is_separator ||
                   rsp_last_char !== want.last_char) begin
                  if (fail_count < 10)
                     $display("%0t: expected char %h sep %b last %b, got char %h sep %b last %b",
                              $time, want.out_char, want.is_separator, want.last_char,
                              rsp_out_char, rsp_is_separator, rsp_last_char);
                  fail_count++;
               end
               chars_checked++;
               if (want.is_separator) separators_checked++;
               if (want.last_char) messages_checked++;
            end
         end
      end
      pending_count = expected_chars.size();
   end

endmodule

@@ tb/base32_grouped_serial_encoder_core_tb.sv @@
// Testbench top for the grouped base32 encoder: byte stimulus, register writes and verdict.
module base32_grouped_serial_encoder_core_tb;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int HOLD_CYCLES   = 200;
   localparam int SETTLE_CYCLES = 12;
   localparam int PHASES        = 8;
   localparam int PHASE_BYTES   = 50;
   localparam logic [bgse_pkg::CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   typedef enum int {RX_ALWAYS, RX_RANDOM, RX_SLOW, RX_PATTERN} rx_mode_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_push = 1'b0;
   logic [bgse_pkg::BYTE_W-1:0]      req_data_byte = '0;
   logic                             req_end_of_message = 1'b0;
   logic                             req_full;
   logic                             rsp_empty;
   logic                             rsp_pop = 1'b0;
   logic [bgse_pkg::BYTE_W-1:0]      rsp_out_char;
   logic                             rsp_is_separator;
   logic                             rsp_last_char;
   logic                             csr_we = 1'b0;
   logic [bgse_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [bgse_pkg::BYTE_W-1:0]      csr_wdata = '0;

   int fail_count;
   int pending_count;
   int chars_checked;
   int separators_checked;
   int messages_checked;

   rx_mode_type rx_mode = RX_ALWAYS;
   int       hold_requests = 0;
   int       holds_done = 0;
   int       burst_left = 0;
   bit       gaps_on = 1'b0;
   int       bytes_sent = 0;
   int       reg_writes = 0;
   int       full_stalls = 0;
   int       cycles = 0;

   base32_grouped_serial_encoder_core uut (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_data_byte      (req_data_byte),
      .req_end_of_message (req_end_of_message),
      .req_full           (req_full),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_out_char       (rsp_out_char),
      .rsp_is_separator   (rsp_is_separator),
      .rsp_last_char      (rsp_last_char),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   bgse_char_check char_check (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_data_byte      (req_data_byte),
      .req_end_of_message (req_end_of_message),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_out_char       (rsp_out_char),
      .rsp_is_separator   (rsp_is_separator),
      .rsp_last_char      (rsp_last_char),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .fail_count         (fail_count),
      .pending_count      (pending_count),
      .chars_checked      (chars_checked),
      .separators_checked (separators_checked),
      .messages_checked   (messages_checked)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (!reset && req_push && req_full) full_stalls++;
   end

   initial begin : watchdog
      wait (cycles >= CYCLE_LIMIT);
      $display("CHECK FAILED");
      $finish;
   end

   initial begin : receiver
      int tick;
      tick = 0;
      forever begin
         @(negedge clock);
         if (holds_done != hold_requests) begin
            rsp_pop = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            holds_done++;
         end
         tick++;
         case (rx_mode)
            RX_ALWAYS: rsp_pop = 1'b1;
            RX_RANDOM: rsp_pop = 1'($urandom_range(0, 1));
            RX_SLOW:   rsp_pop = ($urandom_range(0, 3) == 0);
            default:   rsp_pop = (tick % 7) < 4;
         endcase
      end
   end

   task automatic write_reg(input logic [bgse_pkg::CSR_INDEX_W-1:0] index,
                            input logic [bgse_pkg::BYTE_W-1:0] value);
      csr_we = 1'b1;
      csr_index = index;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
      reg_writes++;
   endtask

   // called at a falling edge; returns at the falling edge after the transfer
   task automatic offer_byte(input logic [7:0] data, input logic eom);
      if (burst_left == 0) begin
         if (gaps_on) begin
            req_push = 1'b0;
            repeat ($urandom_range(0, 5)) @(negedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      req_push = 1'b1;
      req_data_byte = data;
      req_end_of_message = eom;
      @(posedge clock);
      while (req_full) @(posedge clock);
      @(negedge clock);
      burst_left--;
      bytes_sent++;
   endtask

   task automatic send_message(input int len, input bit close);
      logic [7:0] data;
      for (int i = 0; i < len; i++) begin
         case ($urandom_range(0, 9))
            0:       data = 8'hFF;
            1:       data = 8'h00;
            default: data = 8'($urandom_range(0, 255));
         endcase
         offer_byte(data, close && i == len - 1);
      end
   endtask

   task automatic wait_idle();
      req_push = 1'b0;
      wait (pending_count == 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin : stimulus
      logic [7:0] gs_value;
      int         phase_bytes;
      int         len;
      bit         close;
      repeat (7) @(negedge clock);
      reset = 1'b0;

      // reset settings: group of 5, dash separator, zero byte for symbol 31
      offer_byte(8'h00, 1'b1);
      offer_byte(8'hFF, 1'b1);
      repeat (4) offer_byte(8'hFF, 1'b0);
      offer_byte(8'hFF, 1'b1);
      offer_byte(8'hA5, 1'b0);
      offer_byte(8'h5A, 1'b0);
      offer_byte(8'hC3, 1'b1);

      // group size lowered mid-message
      offer_byte(8'hFF, 1'b0);
      offer_byte(8'h00, 1'b0);
      wait_idle();
      write_reg(bgse_pkg::CSR_GROUP_SIZE, 8'd2);
      offer_byte(8'h0F, 1'b1);
      wait_idle();

      write_reg(bgse_pkg::CSR_GROUP_SIZE, 8'd1);
      write_reg(bgse_pkg::CSR_SEPARATOR_CHAR, 8'hFF);
      write_reg(bgse_pkg::CSR_SYMBOL31_CHAR, 8'hFF);
      offer_byte(8'hFF, 1'b0);
      offer_byte(8'hFF, 1'b1);
      wait_idle();

      // grouping off
      write_reg(bgse_pkg::CSR_GROUP_SIZE, 8'd0);
      repeat (3) offer_byte(8'h00, 1'b0);
      offer_byte(8'h00, 1'b1);
      wait_idle();

      // write to an index with no register must change nothing
      write_reg(CSR_UNUSED, 8'hFF);
      offer_byte(8'h3C, 1'b0);
      offer_byte(8'hE1, 1'b0);
      offer_byte(8'h7E, 1'b1);
      wait_idle();

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0:       gs_value = 8'd31;
            1:       gs_value = 8'd16;
            2:       gs_value = 8'd3;
            3:       gs_value = 8'd0;
            4:       gs_value = 8'd1;
            5:       gs_value = 8'hE7;
            6:       gs_value = 8'd4;
            default: gs_value = 8'($urandom_range(0, 31));
         endcase
         write_reg(bgse_pkg::CSR_GROUP_SIZE, gs_value);
         write_reg(bgse_pkg::CSR_SEPARATOR_CHAR,
                   phase == 0 ? 8'h00 : phase == 1 ? 8'hFF : 8'($urandom_range(0, 255)));
         write_reg(bgse_pkg::CSR_SYMBOL31_CHAR,
                   phase == 0 ? 8'hFF : phase == 1 ? 8'h00 : 8'($urandom_range(0, 255)));
         if (phase == 4) write_reg(CSR_UNUSED, 8'($urandom_range(0, 255)));
         rx_mode = rx_mode_type'(phase % 4);
         gaps_on = (phase % 3) != 0;
         if (phase == 2 || phase == 6) hold_requests++;

         phase_bytes = 0;
         while (phase_bytes < PHASE_BYTES) begin
            if ((gs_value == 8'd31 || gs_value == 8'd0) && $urandom_range(0, 3) == 0)
               len = $urandom_range(20, 40);
            else
               len = $urandom_range(1, 10);
            // odd phases leave the last message open across the next register writes
            close = !(phase % 2 == 1 && phase_bytes + len >= PHASE_BYTES);
            send_message(len, close);
            phase_bytes += len;
         end
         wait_idle();
      end

      rx_mode = RX_ALWAYS;
      wait_idle();

      $display("Encoded %0d bytes with %0d register writes; %0d characters checked.",
               bytes_sent, reg_writes, chars_checked);
      $display("%0d separators, %0d completed messages, input held off %0d cycles by full.",
               separators_checked, messages_checked, full_stalls);
      if (fail_count == 0 && pending_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
